>>> src/apns_pkg.sv
// Shared types, constants and nibble selection for the analog pad serializer.
package apns_pkg;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_t;

  // Input beat payload; first field sits in the high bits of tdata.
  typedef struct packed {
    logic [7:0] button_bits;
    logic [7:0] throttle_z;
    logic [7:0] stick_y;
    logic [7:0] stick_x;
    logic [7:0] write_mask;
    logic [7:0] write_data;
  } item_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int RD_W     = 7;
  localparam int OUT_W    = 8;
  localparam int LINE_BIT = 6;

  localparam logic [2:0] SEQ_CAP      = 3'd4;  // phase 32
  localparam logic [7:0] READ_LATENCY = 8'd2;

  // Nibble selectors, phase_count / 4
  localparam logic [3:0] SEL_BTN_HI = 4'd0;
  localparam logic [3:0] SEL_BTN_LO = 4'd1;
  localparam logic [3:0] SEL_X_HI   = 4'd2;
  localparam logic [3:0] SEL_Y_HI   = 4'd3;
  localparam logic [3:0] SEL_Z_HI   = 4'd5;
  localparam logic [3:0] SEL_X_LO   = 4'd6;
  localparam logic [3:0] SEL_Y_LO   = 4'd7;
  localparam logic [3:0] SEL_Z_LO   = 4'd9;

  function automatic logic [3:0] pick_nibble(input logic [3:0] sel, input item_t it);
    logic [7:0] inv;
    inv = ~it.button_bits;
    unique case (sel)
      SEL_BTN_HI: return inv[7:4];
      SEL_BTN_LO: return inv[3:0];
      SEL_X_HI:   return it.stick_x[7:4];
      SEL_Y_HI:   return it.stick_y[7:4];
      SEL_Z_HI:   return it.throttle_z[7:4];
      SEL_X_LO:   return it.stick_x[3:0];
      SEL_Y_LO:   return it.stick_y[3:0];
      SEL_Z_LO:   return it.throttle_z[3:0];
      default:    return 4'h0;
    endcase
  endfunction

endpackage

>>> src/analog_pad_nibble_serializer.sv
// Top level: stream ports, port state core and output skid stage.
// One port access is taken per clock while s_axis_tready is high. A read
// beat produces one registered result beat; a write beat only updates the
// port state and produces nothing. The output register plus a one-entry
// skid stage let input beats keep flowing while one result waits;
// s_axis_tready drops only once both hold undelivered results.
module analog_pad_nibble_serializer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: write_data, write_mask, stick_x, stick_y, throttle_z, button_bits
  input  logic [apns_pkg::ITEM_W-1:0]  s_axis_tdata,
  // tuser: req_type
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: read_data[6:0], zero pad bit 7
  output logic [apns_pkg::OUT_W-1:0]   m_axis_tdata
);

  logic                       s_accept;
  logic                       res_valid;
  logic [apns_pkg::RD_W-1:0]  res_word;
  apns_pkg::req_t             req;
  apns_pkg::item_t            item;

  logic                       out_valid, out_valid_next;
  logic [apns_pkg::RD_W-1:0]  out_data, out_data_next;
  logic                       skid_valid, skid_valid_next;
  logic [apns_pkg::RD_W-1:0]  skid_data;

  assign req       = apns_pkg::req_t'(s_axis_tuser);
  assign item      = apns_pkg::item_t'(s_axis_tdata);
  assign s_accept  = s_axis_tvalid && s_axis_tready;
  assign res_valid = s_accept && (req == apns_pkg::REQ_READ);

  apns_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_accept),
    .req       (req),
    .item      (item),
    .read_word (res_word)
  );

  always_comb begin
    out_valid_next  = out_valid;
    out_data_next   = out_data;
    skid_valid_next = skid_valid;
    if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid_next  = 1'b1;
        out_data_next   = skid_data;
        skid_valid_next = 1'b0;
      end else begin
        out_valid_next = res_valid;
        out_data_next  = res_word;
      end
    end else if (res_valid) begin
      skid_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
    if (res_valid && out_valid && !m_axis_tready) begin
      skid_data <= res_word;
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_data};

endmodule

>>> src/apns_core.sv
// Port state (line level, phase, read count) and read word formation.
module apns_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  apns_pkg::req_t           req,
  input  apns_pkg::item_t          item,
  output logic [apns_pkg::RD_W-1:0] read_word
);

  logic       line_level, line_level_next;
  logic [5:0] phase_count, phase_count_next;
  logic [7:0] reads_since_start, reads_since_start_next;

  logic [2:0] cyc;
  logic       new_level;
  logic [3:0] seq_inc;
  logic [2:0] seq_capped;

  assign cyc = phase_count[2:0];
  assign read_word = {1'b1, (cyc[1:0] == 2'b00), cyc[2],
                      apns_pkg::pick_nibble(phase_count[5:2], item)};

  assign new_level = item.write_mask[apns_pkg::LINE_BIT] ?
                     item.write_data[apns_pkg::LINE_BIT] : line_level;
  assign seq_inc    = {1'b0, phase_count[5:3]} + 4'd1;
  assign seq_capped = (seq_inc > {1'b0, apns_pkg::SEQ_CAP}) ? apns_pkg::SEQ_CAP
                                                             : seq_inc[2:0];

  always_comb begin
    line_level_next        = line_level;
    phase_count_next       = phase_count;
    reads_since_start_next = reads_since_start;
    if (accept) begin
      if (req == apns_pkg::REQ_READ) begin
        phase_count_next       = {phase_count[5:3], cyc + 3'd1};
        reads_since_start_next = reads_since_start + 8'd1;
      end else begin
        line_level_next = new_level;
        priority if (!new_level && line_level) begin
          // falling edge restarts acquisition
          phase_count_next       = '0;
          reads_since_start_next = '0;
        end else if (reads_since_start > apns_pkg::READ_LATENCY) begin
          phase_count_next = {seq_capped, 3'b000};
        end else begin
          phase_count_next = phase_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_level        <= 1'b1;
      phase_count       <= '0;
      reads_since_start <= '0;
    end else begin
      line_level        <= line_level_next;
      phase_count       <= phase_count_next;
      reads_since_start <= reads_since_start_next;
    end
  end

endmodule

>>> src/apns_checker.sv
// Port-level checks for the analog pad serializer, bound to the top level.
module apns_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [apns_pkg::OUT_W-1:0]   m_axis_tdata
);

  // every result carries the fixed high bit and a zero pad bit
  a_fixed_bits: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[6] == 1'b1) && (m_axis_tdata[7] == 1'b0))
    else $error("result fixed bits wrong");

  // input only backs up once a result is actually held
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a held result");

  // a read into an empty block shows up next cycle
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid)
      |=> m_axis_tvalid)
    else $error("read beat lost");

  // a write into an empty block makes no result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid)
      |=> !m_axis_tvalid)
    else $error("write beat produced a result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind analog_pad_nibble_serializer apns_checker u_apns_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/apns_checker.sv
// Port-state predictor and result scoreboard for the analog pad serializer.
`timescale 1ns / 1ps

module apns_scoreboard (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  // tdata: write_data, write_mask, stick_x, stick_y, throttle_z, button_bits
  input  logic [apns_pkg::ITEM_W-1:0]  s_axis_tdata,
  // tuser: req_type
  input  logic                         s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: read_data[6:0], zero pad bit 7
  input  logic [apns_pkg::OUT_W-1:0]   m_axis_tdata,
  output int                           fail_count,
  output int                           words_pending
);

  localparam logic [6:0] PHASE_CAP = 7'd32;

  logic                      line_lvl;
  logic [5:0]                phase;      // sequence in [5:3], cycle in [2:0]
  logic [7:0]                reads;
  logic [apns_pkg::RD_W-1:0] words_due[$];
  int                        fails = 0;

  always @(posedge clk) begin : track
    apns_pkg::item_t           it;
    logic [3:0]                nib;
    logic [6:0]                next_phase;
    logic                      new_lvl;
    logic [apns_pkg::RD_W-1:0] want;
    if (rst) begin
      line_lvl = 1'b1;
      phase    = '0;
      reads    = '0;
      words_due.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        it = apns_pkg::item_t'(s_axis_tdata);
        if (apns_pkg::req_t'(s_axis_tuser) == apns_pkg::REQ_READ) begin
          case (phase[5:2])
            apns_pkg::SEL_BTN_HI: nib = ~it.button_bits[7:4];
            apns_pkg::SEL_BTN_LO: nib = ~it.button_bits[3:0];
            apns_pkg::SEL_X_HI:   nib = it.stick_x[7:4];
            apns_pkg::SEL_Y_HI:   nib = it.stick_y[7:4];
            apns_pkg::SEL_Z_HI:   nib = it.throttle_z[7:4];
            apns_pkg::SEL_X_LO:   nib = it.stick_x[3:0];
            apns_pkg::SEL_Y_LO:   nib = it.stick_y[3:0];
            apns_pkg::SEL_Z_LO:   nib = it.throttle_z[3:0];
            default:              nib = 4'h0;
          endcase
          // bit 5 flags the first read of each half, bit 4 the half itself
          words_due.push_back({1'b1, phase[1:0] == 2'b00, phase[2], nib});
          phase = {phase[5:3], phase[2:0] + 3'd1};
          reads = reads + 8'd1;
        end else begin
          new_lvl = it.write_mask[apns_pkg::LINE_BIT] ? it.write_data[apns_pkg::LINE_BIT]
                                                      : line_lvl;
          if (line_lvl && !new_lvl) begin
            phase = '0;
            reads = '0;
          end else if (reads > apns_pkg::READ_LATENCY) begin
            next_phase = {1'b0, phase & 6'h38} + 7'd8;
            if (next_phase > PHASE_CAP)
              next_phase = PHASE_CAP;
            phase = next_phase[5:0];
          end
          line_lvl = new_lvl;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (words_due.size() == 0) begin
          $error("read_data: no beat expected, actual %02h",
                 m_axis_tdata[apns_pkg::RD_W-1:0]);
          fails++;
        end else begin
          want = words_due.pop_front();
          if (m_axis_tdata[apns_pkg::RD_W-1:0] !== want) begin
            $error("read_data: expected %02h, actual %02h", want,
                   m_axis_tdata[apns_pkg::RD_W-1:0]);
            fails++;
          end
          if (m_axis_tdata[apns_pkg::OUT_W-1:apns_pkg::RD_W] !== '0) begin
            $error("pad: expected 0, actual %0h",
                   m_axis_tdata[apns_pkg::OUT_W-1:apns_pkg::RD_W]);
            fails++;
          end
        end
      end
    end
    fail_count    <= fails;
    words_pending <= words_due.size();
  end

endmodule

>>> tb/sv/tb_analog_pad_nibble_serializer.sv
// Stimulus and verdict for the analog pad serializer.
`timescale 1ns / 1ps

module tb_analog_pad_nibble_serializer;

  localparam int NUM_BEATS   = 1850;
  localparam int CYCLE_LIMIT = 200000;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [apns_pkg::ITEM_W-1:0] s_axis_tdata = '0;
  logic                        s_axis_tuser = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [apns_pkg::OUT_W-1:0]  m_axis_tdata;

  int   fail_count;
  int   words_pending;
  int   beats_sent = 0;
  int   cycles = 0;
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;

  analog_pad_nibble_serializer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  apns_scoreboard u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= rx_steady || ($urandom_range(0, 99) >= 9);
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send(input apns_pkg::req_t req, input logic [7:0] wd,
                      input logic [7:0] wm,
                      input logic [7:0] sx, input logic [7:0] sy,
                      input logic [7:0] sz, input logic [7:0] bb);
    apns_pkg::item_t it;
    it = '{button_bits: bb, throttle_z: sz, stick_y: sy, stick_x: sx,
           write_mask: wm, write_data: wd};
    while (!tx_steady && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    s_axis_tuser  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    beats_sent++;
    tx_steady = (beats_sent >= 600 && beats_sent < 900);
    rx_steady <= (beats_sent >= 1200 && beats_sent < 1500);
  endtask

  task automatic send_read();
    send(apns_pkg::REQ_READ, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte(),
         rnd_byte(), rnd_byte());
  endtask

  initial begin
    int n_seq;
    int n_reads;
    int n_noise;
    logic [7:0] wd;
    logic [7:0] wm;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // full first sequence: both halves, inverted buttons, cycle wrap
    send(apns_pkg::REQ_READ, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send(apns_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF);
    send(apns_pkg::REQ_READ, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hA5);
    send(apns_pkg::REQ_READ, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h5A);
    send(apns_pkg::REQ_READ, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send(apns_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF);
    send(apns_pkg::REQ_READ, 8'hFF, 8'hFF, 8'h0F, 8'hF0, 8'h3C, 8'hC3);
    send(apns_pkg::REQ_READ, 8'h00, 8'h00, 8'hF0, 8'h0F, 8'hC3, 8'h3C);
    // unmasked write: line stays high, more than two reads so it advances
    send(apns_pkg::REQ_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send(apns_pkg::REQ_READ, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send(apns_pkg::REQ_READ, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
    send(apns_pkg::REQ_WRITE, 8'h00, 8'hBF, 8'h00, 8'h00, 8'h00, 8'h00);
    send(apns_pkg::REQ_WRITE, 8'h40, 8'h40, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send(apns_pkg::REQ_WRITE, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
    // already at the cap, this one must hold phase at 32
    send(apns_pkg::REQ_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    repeat (4) send(apns_pkg::REQ_READ, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
    repeat (4) send(apns_pkg::REQ_READ, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
    // falling edge restarts, a held-low write does nothing, a rise with few reads too
    send(apns_pkg::REQ_WRITE, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00);
    send(apns_pkg::REQ_WRITE, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00);
    send(apns_pkg::REQ_READ, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78);
    send(apns_pkg::REQ_WRITE, 8'h40, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00);

    // let everything drain once before the random part
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);

    while (beats_sent < NUM_BEATS) begin
      if ($urandom_range(0, 99) < 80) begin
        // acquisition frame: raise, drop, then sequences of reads and advances
        send(apns_pkg::REQ_WRITE, rnd_byte() | 8'h40, rnd_byte() | 8'h40,
             rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
        send(apns_pkg::REQ_WRITE, rnd_byte() & 8'hBF, rnd_byte() | 8'h40,
             rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
        n_seq = $urandom_range(1, 6);
        for (int s = 0; s < n_seq; s++) begin
          n_reads = $urandom_range(0, 9);
          for (int r = 0; r < n_reads; r++) send_read();
          wd = rnd_byte();
          wm = rnd_byte();
          if ($urandom_range(0, 7) != 0)
            wd = wd & 8'hBF;
          send(apns_pkg::REQ_WRITE, wd, wm, rnd_byte(), rnd_byte(), rnd_byte(),
               rnd_byte());
        end
      end else begin
        n_noise = $urandom_range(1, 8);
        for (int k = 0; k < n_noise; k++)
          send(apns_pkg::req_t'($urandom_range(0, 1)), rnd_byte(), rnd_byte(),
               rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte());
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> analog_pad_nibble_serializer.f
src/apns_pkg.sv
src/apns_core.sv
src/analog_pad_nibble_serializer.sv
src/apns_checker.sv
tb/sv/apns_checker.sv
tb/sv/tb_analog_pad_nibble_serializer.sv
